// ===== rtl/q2e_pkg.sv =====
`default_nettype none
package q2e_pkg;

   localparam int ARG_W       = 34;
   localparam int S_W         = 32;
   localparam int X_W         = 37;
   localparam int Z_W         = 35;
   localparam int N_W         = 61;
   localparam int R_W         = 31;
   localparam int SQRT_STAGES = 31;
   localparam int TABLE_LEN   = 24;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = 2;
   localparam int ANGLE_W     = 16;
   localparam int PITCH_W     = 15;
   localparam int ANG_MAX     = 25736;
   localparam int PITCH_MAX   = 12868;

   localparam logic signed [ARG_W-1:0] ONE_Q30 = 34'sd1073741824;
   localparam logic signed [Z_W-1:0]   PI_Q30  = 35'sd3373259426;

   typedef struct packed {
      logic signed [ARG_W-1:0] rn;
      logic signed [ARG_W-1:0] rd;
      logic signed [ARG_W-1:0] yn;
      logic signed [ARG_W-1:0] yd;
      logic signed [S_W-1:0]   s;
   } q2e_args_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic [29:0] atan_q30(input int unsigned idx);
      logic [29:0] r;
      case (idx)
         0:       r = 30'd843314856;
         1:       r = 30'd497837829;
         2:       r = 30'd263043836;
         3:       r = 30'd133525158;
         4:       r = 30'd67021686;
         5:       r = 30'd33543515;
         6:       r = 30'd16775850;
         7:       r = 30'd8388437;
         8:       r = 30'd4194282;
         9:       r = 30'd2097149;
         10:      r = 30'd1048575;
         11:      r = 30'd524287;
         12:      r = 30'd262143;
         13:      r = 30'd131071;
         14:      r = 30'd65535;
         15:      r = 30'd32767;
         16:      r = 30'd16383;
         17:      r = 30'd8191;
         18:      r = 30'd4095;
         19:      r = 30'd2047;
         20:      r = 30'd1023;
         21:      r = 30'd511;
         22:      r = 30'd255;
         23:      r = 30'd127;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/q2e_front.sv =====
`default_nettype none
module q2e_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic signed [15:0]    quat_w,
   input  wire logic signed [15:0]    quat_x,
   input  wire logic signed [15:0]    quat_y,
   input  wire logic signed [15:0]    quat_z,
   input  wire logic                  q_full,
   output logic                       push,
   output q2e_pkg::q2e_args_type      push_data
);

   logic               p_v_ff, a_v_ff;
   logic               p_adv, a_adv;
   logic signed [31:0] zy_ff, wx_ff, xx_ff, yy_ff, zw_ff, xy_ff, zz_ff, yw_ff, zx_ff;
   logic signed [q2e_pkg::ARG_W-1:0] rn_in, rd_in, yn_in, yd_in, s_t;
   logic signed [q2e_pkg::S_W-1:0]   s_in;
   q2e_pkg::q2e_args_type            args_ff;

   assign a_adv      = !a_v_ff || !q_full;
   assign p_adv      = !p_v_ff || a_adv;
   assign req_tready = p_adv;
   assign push       = a_v_ff && !q_full;
   assign push_data  = args_ff;

   always_comb begin
      rn_in = (34'(zy_ff) + 34'(wx_ff)) <<< 1;
      rd_in = q2e_pkg::ONE_Q30 - ((34'(xx_ff) + 34'(yy_ff)) <<< 1);
      yn_in = (34'(zw_ff) + 34'(xy_ff)) <<< 1;
      yd_in = q2e_pkg::ONE_Q30 - ((34'(yy_ff) + 34'(zz_ff)) <<< 1);
      s_t   = (34'(yw_ff) - 34'(zx_ff)) <<< 1;
      if (s_t > q2e_pkg::ONE_Q30) begin
         s_in = 32'sd1073741824;
      end else if (s_t < -q2e_pkg::ONE_Q30) begin
         s_in = -32'sd1073741824;
      end else begin
         s_in = signed'(s_t[q2e_pkg::S_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         a_v_ff <= 1'b0;
      end else begin
         if (p_adv) p_v_ff <= req_tvalid;
         if (a_adv) a_v_ff <= p_v_ff;
      end
      if (p_adv) begin
         zy_ff <= quat_z * quat_y;
         wx_ff <= quat_w * quat_x;
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         zw_ff <= quat_z * quat_w;
         xy_ff <= quat_x * quat_y;
         zz_ff <= quat_z * quat_z;
         yw_ff <= quat_y * quat_w;
         zx_ff <= quat_z * quat_x;
      end
      if (a_adv) begin
         args_ff.rn <= rn_in;
         args_ff.rd <= rd_in;
         args_ff.yn <= yn_in;
         args_ff.yd <= yd_in;
         args_ff.s  <= s_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/q2e_fifo.sv =====
`default_nettype none
module q2e_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire q2e_pkg::q2e_args_type  push_data,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        not_empty,
   output q2e_pkg::q2e_args_type       head
);

   q2e_pkg::q2e_args_type          mem_ff [0:q2e_pkg::FIFO_DEPTH-1];
   logic [q2e_pkg::FIFO_AW-1:0]    wr_ff, rd_ff;
   logic [q2e_pkg::FIFO_AW:0]      cnt_ff;

   assign full      = (cnt_ff == (q2e_pkg::FIFO_AW+1)'(q2e_pkg::FIFO_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ===== rtl/q2e_cordic.sv =====
`default_nettype none
module q2e_cordic #(
   parameter int STEPS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic signed [q2e_pkg::X_W-1:0] y_in,
   input  wire logic signed [q2e_pkg::X_W-1:0] x_in,
   output logic signed [q2e_pkg::Z_W-1:0]     z_out,
   output logic                               zero_out
);

   localparam int N = (STEPS > q2e_pkg::TABLE_LEN) ? q2e_pkg::TABLE_LEN : STEPS;

   logic signed [q2e_pkg::X_W-1:0] x_ff [0:N];
   logic signed [q2e_pkg::X_W-1:0] y_ff [0:N];
   logic signed [q2e_pkg::Z_W-1:0] z_ff [0:N];
   logic                           zero_ff [0:N];

   // quadrant fold
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            z_ff[0] <= (y_in >= 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
         end else begin
            z_ff[0] <= '0;
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + q2e_pkg::Z_W'(q2e_pkg::atan_q30(i));
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - q2e_pkg::Z_W'(q2e_pkg::atan_q30(i));
            end
         end
      end
   end

   assign z_out    = z_ff[N];
   assign zero_out = zero_ff[N];

endmodule
`default_nettype wire

// ===== rtl/q2e_back.sv =====
`default_nettype none
module q2e_back #(
   parameter int STEPS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire q2e_pkg::q2e_args_type  head,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic signed [15:0]          roll_angle,
   output logic signed [14:0]          pitch_angle,
   output logic signed [15:0]          yaw_angle
);

   localparam int N   = (STEPS > q2e_pkg::TABLE_LEN) ? q2e_pkg::TABLE_LEN : STEPS;
   localparam int LAT = 2 + q2e_pkg::SQRT_STAGES + N;
   localparam int SQ  = q2e_pkg::SQRT_STAGES;

   logic                            en;
   logic [LAT-1:0]                  v_ff;
   logic                            out_v_ff;
   logic signed [63:0]              sq;
   q2e_pkg::q2e_args_type           arg_ff  [0:SQ];
   logic [q2e_pkg::N_W-1:0]         rem_ff  [0:SQ];
   logic [q2e_pkg::R_W-1:0]         root_ff [0:SQ];
   logic signed [q2e_pkg::Z_W-1:0]  roll_z, pitch_z, yaw_z;
   logic                            roll_zero, pitch_zero, yaw_zero;
   logic signed [15:0]              roll_ff, yaw_ff, pitch_w;
   logic signed [14:0]              pitch_ff;

   function automatic logic signed [15:0] to_q13(input logic signed [q2e_pkg::Z_W-1:0] a,
                                                 input logic [14:0] lim);
      logic [q2e_pkg::Z_W-1:0] mag;
      logic [q2e_pkg::Z_W:0]   sum;
      logic [18:0]             t;
      logic [15:0]             r;
      mag = (a < 0) ? unsigned'(-a) : unsigned'(a);
      sum = {1'b0, mag} + 36'd65536;
      t   = sum[q2e_pkg::Z_W:17];
      r   = (t > 19'(lim)) ? 16'(lim) : t[15:0];
      return (a < 0) ? -signed'(r) : signed'(r);
   endfunction

   assign en         = !out_v_ff || rsp_tready;
   assign pop        = en && head_valid;
   assign rsp_tvalid = out_v_ff;
   assign roll_angle  = roll_ff;
   assign pitch_angle = pitch_ff;
   assign yaw_angle   = yaw_ff;
   assign sq          = head.s * head.s;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v_ff     <= {v_ff[LAT-2:0], pop};
         out_v_ff <= v_ff[LAT-1];
      end
      if (en) begin
         arg_ff[0]  <= head;
         rem_ff[0]  <= q2e_pkg::N_W'(64'h1000_0000_0000_0000 - unsigned'(sq));
         root_ff[0] <= '0;
      end
   end

   // one root bit a stage, MSB first
   for (genvar j = 0; j < SQ; j++) begin : g_sqrt
      localparam int K = SQ - 1 - j;
      logic [63:0] cand;
      assign cand = (64'(root_ff[j]) << (K + 1)) + (64'd1 << (2 * K));
      always_ff @(posedge clock) begin
         if (en) begin
            arg_ff[j+1] <= arg_ff[j];
            if (64'(rem_ff[j]) >= cand) begin
               rem_ff[j+1]  <= q2e_pkg::N_W'(64'(rem_ff[j]) - cand);
               root_ff[j+1] <= root_ff[j] | (q2e_pkg::R_W'(1) << K);
            end else begin
               rem_ff[j+1]  <= rem_ff[j];
               root_ff[j+1] <= root_ff[j];
            end
         end
      end
   end

   q2e_cordic #(.STEPS(N)) u_roll (
      .clock    (clock),
      .en       (en),
      .y_in     (q2e_pkg::X_W'(arg_ff[SQ].rn)),
      .x_in     (q2e_pkg::X_W'(arg_ff[SQ].rd)),
      .z_out    (roll_z),
      .zero_out (roll_zero)
   );

   q2e_cordic #(.STEPS(N)) u_pitch (
      .clock    (clock),
      .en       (en),
      .y_in     (q2e_pkg::X_W'(arg_ff[SQ].s)),
      .x_in     (signed'(q2e_pkg::X_W'(root_ff[SQ]))),
      .z_out    (pitch_z),
      .zero_out (pitch_zero)
   );

   q2e_cordic #(.STEPS(N)) u_yaw (
      .clock    (clock),
      .en       (en),
      .y_in     (q2e_pkg::X_W'(arg_ff[SQ].yn)),
      .x_in     (q2e_pkg::X_W'(arg_ff[SQ].yd)),
      .z_out    (yaw_z),
      .zero_out (yaw_zero)
   );

   assign pitch_w = to_q13(pitch_z, 15'(q2e_pkg::PITCH_MAX));

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff  <= roll_zero  ? '0 : to_q13(roll_z, 15'(q2e_pkg::ANG_MAX));
         pitch_ff <= pitch_zero ? '0 : signed'(pitch_w[q2e_pkg::PITCH_W-1:0]);
         yaw_ff   <= yaw_zero   ? '0 : to_q13(yaw_z, 15'(q2e_pkg::ANG_MAX));
      end
   end

endmodule
`default_nettype wire

// ===== rtl/quaternion_to_euler_321_top.sv =====
`default_nettype none
// Quaternion (Q1.15) to roll / pitch / yaw (z-y-x Tait-Bryan, radians Q13).
// Takes one quaternion a cycle and gives one result beat a cycle while
// rsp_tready is held high. The path runs through two product/sum stages,
// the queue, one squaring stage, 31 square-root stages (one root bit each,
// for the cosine of pitch), a quadrant-fold stage plus CORDIC_STEPS
// vectoring stages (CORDIC_STEPS capped at 24), and the rounding output
// register. The back end pipeline halts as a whole while a result beat is
// held; the four-deep queue and the two front stages then take up to six
// more beats before req_tready drops. The asin argument is clamped to
// [-1, 1]; atan2(0, 0) gives 0.
module quaternion_to_euler_321_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // quat_w, quat_x, quat_y, quat_z
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata   // roll_angle, pitch_angle, yaw_angle, pad
);

   logic                  push, q_full, q_pop, q_nempty;
   q2e_pkg::q2e_args_type push_data, q_head;
   logic signed [15:0]    roll_angle, yaw_angle;
   logic signed [14:0]    pitch_angle;

   q2e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .quat_w     (signed'(req_tdata[15:0])),
      .quat_x     (signed'(req_tdata[31:16])),
      .quat_y     (signed'(req_tdata[47:32])),
      .quat_z     (signed'(req_tdata[63:48])),
      .q_full     (q_full),
      .push       (push),
      .push_data  (push_data)
   );

   q2e_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_nempty),
      .head      (q_head)
   );

   q2e_back #(.STEPS(CORDIC_STEPS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_nempty),
      .head        (q_head),
      .pop         (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .roll_angle  (roll_angle),
      .pitch_angle (pitch_angle),
      .yaw_angle   (yaw_angle)
   );

   assign rsp_tdata = {1'b0, yaw_angle, pitch_angle, roll_angle};

endmodule
`default_nettype wire

// ===== dv/quaternion_to_euler_321_top_tb.sv =====
`timescale 1ns / 1ps
module quaternion_to_euler_321_top_tb;

   localparam int CORDIC_STEPS = 16;
   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam int N_RANDOM = 2000;

   typedef struct packed {
      logic signed [15:0] z;
      logic signed [15:0] y;
      logic signed [15:0] x;
      logic signed [15:0] w;
   } quat_type;

   typedef struct packed {
      logic signed [q2e_pkg::ANGLE_W-1:0] yaw;
      logic signed [q2e_pkg::PITCH_W-1:0] pitch;
      logic signed [q2e_pkg::ANGLE_W-1:0] roll;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   quat_type quat_pending[$];
   euler_type euler_expected[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int holdoff = 0;
   bit holdoff_done = 0;
   longint atan_lut[24];

   quaternion_to_euler_321_top #(.CORDIC_STEPS(CORDIC_STEPS)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   initial begin
      atan_lut = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                   16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                   262143, 131071, 65535, 32767, 16383, 8191,
                   4095, 2047, 1023, 511, 255, 127};
   end

   function automatic longint vector_angle(longint ny, longint nx);
      longint ang, xs, ys;
      int n;
      ang = 0;
      n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
      if (nx == 0 && ny == 0) return 0;
      if (nx < 0) begin
         ang = (ny >= 0) ? PI_Q30 : -PI_Q30;
         nx = -nx;
         ny = -ny;
      end
      for (int i = 0; i < n; i++) begin
         xs = nx >>> i;
         ys = ny >>> i;
         if (ny >= 0) begin
            nx = nx + ys;
            ny = ny - xs;
            ang += atan_lut[i];
         end else begin
            nx = nx - ys;
            ny = ny + xs;
            ang -= atan_lut[i];
         end
      end
      return ang;
   endfunction

   function automatic longint root_floor(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint round_q13(longint a, longint lim);
      longint r;
      if (a >= 0) r = (a + 65536) >>> 17;
      else r = -((-a + 65536) >>> 17);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic euler_type quat_to_euler(quat_type q);
      longint w, x, y, z, rn, rd, yn, yd, s, c;
      euler_type e;
      w = longint'(q.w); x = longint'(q.x); y = longint'(q.y); z = longint'(q.z);
      rn = 2 * (z * y + w * x);
      rd = ONE_Q30 - 2 * (x * x + y * y);
      yn = 2 * (z * w + x * y);
      yd = ONE_Q30 - 2 * (y * y + z * z);
      s = 2 * (y * w - z * x);
      if (s > ONE_Q30) s = ONE_Q30;
      if (s < -ONE_Q30) s = -ONE_Q30;
      c = root_floor((64'd1 << 60) - 64'(s * s));
      e.roll = q2e_pkg::ANGLE_W'(round_q13(vector_angle(rn, rd),
                                           longint'(q2e_pkg::ANG_MAX)));
      e.pitch = q2e_pkg::PITCH_W'(round_q13(vector_angle(s, c),
                                            longint'(q2e_pkg::PITCH_MAX)));
      e.yaw = q2e_pkg::ANGLE_W'(round_q13(vector_angle(yn, yd),
                                          longint'(q2e_pkg::ANG_MAX)));
      return e;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            euler_expected.push_back(quat_to_euler(quat_type'(req_tdata)));
            n_sent <= n_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (quat_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= quat_pending.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver, with one long hold-off to fill the pipe
   always @(posedge clock) begin
      if (!holdoff_done && n_sent >= 60) begin
         holdoff = 400;
         holdoff_done = 1;
      end
      if (holdoff > 0) begin
         holdoff--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      euler_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = euler_type'(rsp_tdata[46:0]);
         if (euler_expected.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, got);
            errors++;
         end else begin
            want = euler_expected.pop_front();
            if (got.roll !== want.roll) begin
               $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
               errors++;
            end
            if (got.pitch !== want.pitch) begin
               $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                        got.pitch);
               errors++;
            end
            if (got.yaw !== want.yaw) begin
               $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
               errors++;
            end
            n_checked++;
         end
      end
   end

   task automatic add_quat(int w, int x, int y, int z);
      quat_type q;
      q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
      quat_pending.push_back(q);
   endtask

   task automatic drain;
      while (quat_pending.size() > 0 || req_tvalid || euler_expected.size() > 0)
         @(posedge clock);
      repeat (CORDIC_STEPS + 45) @(posedge clock);
   endtask

   function automatic int rand_comp();
      case ($urandom_range(3))
         0: return int'($signed(16'($urandom)));
         1: return int'($signed(16'($urandom_range(0, 255)))) - 128;
         2: return $urandom_range(1) ? 32767 : -32768;
         default: return int'($signed(16'($urandom))) / 2;
      endcase
   endfunction

   initial begin
      int idle_set[4] = '{0, 85, 0, 22};
      int stall_set[4] = '{0, 0, 85, 22};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, zero args, negative denominators, asin clamp
      add_quat(0, 0, 0, 0);
      add_quat(32767, 0, 0, 0);
      add_quat(-32768, -32768, -32768, -32768);
      add_quat(32767, 32767, 32767, 32767);
      add_quat(0, 32767, 0, 0);
      add_quat(0, -32768, 0, 0);
      add_quat(0, 0, 32767, 0);
      add_quat(0, 0, 0, 32767);
      add_quat(0, 0, 0, -32768);
      add_quat(23170, 0, 23170, 0);
      add_quat(23170, 0, -23170, 0);
      add_quat(32767, 0, 32767, 0);
      add_quat(-32768, 0, 32767, 0);
      add_quat(0, 32767, 0, 32767);
      add_quat(23170, 23170, 0, 0);
      add_quat(23170, -23170, 0, 0);
      add_quat(23170, 0, 0, 23170);
      add_quat(0, 23170, 23170, 0);
      add_quat(16384, 16384, 16384, 16384);
      add_quat(-1, 1, -1, 1);
      add_quat(1, 0, 0, 0);
      add_quat(0, 0, 1, -1);
      drain();
      for (int p = 0; p < 4; p++) begin
         idle_pct = idle_set[p];
         stall_pct = stall_set[p];
         for (int i = 0; i < N_RANDOM / 4; i++)
            add_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
         drain();
      end
      $display("Checked %0d result beats over %0d quaternions:", n_checked, n_sent);
      $display("idle/stall phases, long hold-off, extremes, asin clamp, zero and negative atan2 arguments.");
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #24ms;
      $display("Timeout");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/q2e_pkg.sv
rtl/q2e_front.sv
rtl/q2e_fifo.sv
rtl/q2e_cordic.sv
rtl/q2e_back.sv
rtl/quaternion_to_euler_321_top.sv
dv/quaternion_to_euler_321_top_tb.sv
